// ===== sv/vgm_command_stream_decoder_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the command stream decoder
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef VGM_COMMAND_STREAM_DECODER_UNIT_ASSERT_SVH
`define VGM_COMMAND_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define VGMCSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VGMCSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vgmcsd_pkg.sv =====
// ---------------------------------------------------------------------------
// vgmcsd_pkg
// Opcodes, event kinds and shared types of the command stream decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package vgmcsd_pkg;

  localparam logic [7:0] OP_SKIP   = 8'h4F;
  localparam logic [7:0] OP_TONE   = 8'h50;
  localparam logic [7:0] OP_FM     = 8'h51;
  localparam logic [7:0] OP_WAIT   = 8'h61;
  localparam logic [7:0] OP_WAIT60 = 8'h62;
  localparam logic [7:0] OP_WAIT50 = 8'h63;
  localparam logic [7:0] OP_END    = 8'h66;

  localparam logic [15:0] WAIT_NTSC = 16'd735;
  localparam logic [15:0] WAIT_PAL  = 16'd882;

  localparam logic [2:0] KIND_TONE    = 3'd0;
  localparam logic [2:0] KIND_FM      = 3'd1;
  localparam logic [2:0] KIND_WAIT    = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  // operand collection phase, one-hot
  typedef enum logic [2:0] {
    PH_OPCODE = 3'b001,
    PH_LAST   = 3'b010,
    PH_FIRST  = 3'b100
  } phase_t;

  // decoded event handed to the result register
  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [7:0]  reg_address;
    logic [7:0]  write_value;
    logic [15:0] wait_samples;
  } event_t;

endpackage

`default_nettype wire

// ===== sv/vgmcsd_decode.sv =====
// ---------------------------------------------------------------------------
// vgmcsd_decode
// Byte decode state and per-beat event decode.
// ---------------------------------------------------------------------------
`default_nettype none

module vgmcsd_decode (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           take,
  input  wire logic [7:0]     stream_byte,
  output vgmcsd_pkg::event_t  evt
);
  import vgmcsd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] first_r, first_nxt;
  logic       ended_r, ended_nxt;

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    first_nxt = first_r;
    ended_nxt = ended_r;
    evt       = '0;
    if (!ended_r) begin
      case (phase_r)
        PH_FIRST: begin
          first_nxt = stream_byte;
          phase_nxt = PH_LAST;
        end
        PH_LAST: begin
          phase_nxt = PH_OPCODE;
          case (held_r)
            OP_TONE: begin
              evt.valid       = 1'b1;
              evt.kind        = KIND_TONE;
              evt.write_value = stream_byte;
            end
            OP_FM: begin
              evt.valid       = 1'b1;
              evt.kind        = KIND_FM;
              evt.reg_address = first_r;
              evt.write_value = stream_byte;
            end
            OP_WAIT: begin
              evt.valid        = 1'b1;
              evt.kind         = KIND_WAIT;
              evt.wait_samples = {stream_byte, first_r};
            end
            default: ; // skip opcode: operand dropped
          endcase
        end
        default: begin
          phase_nxt = PH_OPCODE;
          case (stream_byte) inside
            OP_SKIP, OP_TONE: begin
              held_nxt  = stream_byte;
              phase_nxt = PH_LAST;
            end
            OP_FM, OP_WAIT: begin
              held_nxt  = stream_byte;
              phase_nxt = PH_FIRST;
            end
            OP_WAIT60: begin
              evt.valid        = 1'b1;
              evt.kind         = KIND_WAIT;
              evt.wait_samples = WAIT_NTSC;
            end
            OP_WAIT50: begin
              evt.valid        = 1'b1;
              evt.kind         = KIND_WAIT;
              evt.wait_samples = WAIT_PAL;
            end
            OP_END: begin
              ended_nxt = 1'b1;
              evt.valid = 1'b1;
              evt.kind  = KIND_END;
            end
            default: begin
              evt.valid       = 1'b1;
              evt.kind        = KIND_UNKNOWN;
              evt.write_value = stream_byte;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPCODE;
      held_r  <= '0;
      first_r <= '0;
      ended_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      first_r <= first_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vgmcsd_result_reg.sv =====
// ---------------------------------------------------------------------------
// vgmcsd_result_reg
// Result register with valid/ready on the output side.
// ---------------------------------------------------------------------------
`default_nettype none

module vgmcsd_result_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire vgmcsd_pkg::event_t evt,
  input  wire logic           out_ready,
  output logic                space,
  output logic                out_valid,
  output logic [2:0]          out_event_kind,
  output logic [7:0]          out_reg_address,
  output logic [7:0]          out_write_value,
  output logic [15:0]         out_wait_samples
);
  import vgmcsd_pkg::*;

  logic   valid_r;
  event_t data_r;

  // free when empty or draining this cycle
  assign space = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= evt;
    end
  end

  assign out_valid        = valid_r;
  assign out_event_kind   = data_r.kind;
  assign out_reg_address  = data_r.reg_address;
  assign out_write_value  = data_r.write_value;
  assign out_wait_samples = data_r.wait_samples;

endmodule

`default_nettype wire

// ===== sv/vgm_command_stream_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// vgm_command_stream_decoder_unit
// Decodes a music command byte stream into chip write, wait, end and unknown-opcode events.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_stream_byte) takes one stream byte
//   per beat, opcode or operand. Output channel (out_valid/out_ready/out_*)
//   delivers one event beat per completed command: tone write, FM register
//   write, wait, end or unknown opcode. Skip commands and operand bytes that
//   do not finish a command produce no beat.
//   The event shows on out_* in the cycle after the beat that completes
//   its command. One input byte per cycle while the result register has
//   space; the single result register is the only event storage.
//   in_ready = !out_valid || out_ready: a stalled receiver holds the pending
//   event and blocks every input byte, even one that would give no event.
//   Reset (rst_n low, synchronous) empties the result register and returns
//   the decoder to expecting an opcode. After the end opcode every further
//   byte is accepted and dropped until the next reset.
// ---------------------------------------------------------------------------
`default_nettype none

module vgm_command_stream_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_kind,
  output logic [7:0]       out_reg_address,
  output logic [7:0]       out_write_value,
  output logic [15:0]      out_wait_samples
);
  import vgmcsd_pkg::*;

  logic   take;
  logic   space;
  event_t evt;

  // a byte is consumed on every input beat
  assign in_ready = space;
  assign take     = in_valid && space;

  vgmcsd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .stream_byte (in_stream_byte),
    .evt         (evt)
  );

  // load only when the byte actually completes an event
  vgmcsd_result_reg u_result (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (take && evt.valid),
    .evt              (evt),
    .out_ready        (out_ready),
    .space            (space),
    .out_valid        (out_valid),
    .out_event_kind   (out_event_kind),
    .out_reg_address  (out_reg_address),
    .out_write_value  (out_write_value),
    .out_wait_samples (out_wait_samples)
  );

endmodule

`default_nettype wire

// ===== sv/vgmcsd_checker.sv =====
// ---------------------------------------------------------------------------
// vgmcsd_checker
// Port-level checks of the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "vgm_command_stream_decoder_unit_assert.svh"

module vgmcsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_event_kind,
  input wire logic [7:0]  out_reg_address,
  input wire logic [15:0] out_wait_samples
);
  import vgmcsd_pkg::*;

  // a stalled beat stays up
  `VGMCSD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "out beat dropped while stalled")

  // end is the last event of the stream
  `VGMCSD_ASSERT_NEXT(a_end_last, out_valid && out_ready && (out_event_kind == KIND_END), !out_valid, "event after end")

  // address only carried by FM writes
  `VGMCSD_ASSERT_NOW(a_addr_zero, out_valid && (out_event_kind != KIND_FM), out_reg_address == 8'd0, "address on non-FM event")

  // wait count only carried by waits
  `VGMCSD_ASSERT_NOW(a_wait_zero, out_valid && (out_event_kind != KIND_WAIT), out_wait_samples == 16'd0, "wait count on non-wait event")

endmodule

bind vgm_command_stream_decoder_unit vgmcsd_checker u_vgmcsd_checker (.*);

`default_nettype wire
